>>> rtl/core/pnt_pkg.sv
package pnt_pkg;

    // Widths of the words on the ports.
    localparam int CAND_WIDTH    = 16;
    localparam int SUM_OUT_WIDTH = 18;

    // Number of low candidate bits that take part in the test.
    localparam int VALUE_WIDTH = 16;
    localparam int USE_WIDTH   = (VALUE_WIDTH < CAND_WIDTH) ? VALUE_WIDTH : CAND_WIDTH;

    // The proper divisor sum of a value below 2^16 stays below eight times the value.
    localparam int SUM_WIDTH = USE_WIDTH + 3;
    localparam int SAT_WIDTH = (SUM_WIDTH > SUM_OUT_WIDTH) ? SUM_WIDTH : SUM_OUT_WIDTH;
    localparam longint unsigned SUM_OUT_MAX = (64'd1 << SUM_OUT_WIDTH) - 64'd1;

    // Bit counter of the serial remainder unit.
    localparam int CNT_WIDTH = $clog2(USE_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(USE_WIDTH - 1);

    // Microprogram counter and step addresses.
    localparam int UPC_WIDTH = 3;
    typedef logic [UPC_WIDTH-1:0] upc_t;

    localparam upc_t UPC_IDLE = 3'd0;
    localparam upc_t UPC_TEST = 3'd1;
    localparam upc_t UPC_DIV  = 3'd2;
    localparam upc_t UPC_ACC  = 3'd3;
    localparam upc_t UPC_WAIT = 3'd4;
    localparam upc_t UPC_EMIT = 3'd5;

    // Jump conditions: the jump is taken when the condition holds,
    // otherwise the sequencer falls through to the next step.
    typedef logic [2:0] cond_t;

    localparam cond_t COND_NEVER    = 3'd0;
    localparam cond_t COND_ALWAYS   = 3'd1;
    localparam cond_t COND_NO_INPUT = 3'd2;
    localparam cond_t COND_D_GE_N   = 3'd3;
    localparam cond_t COND_CNT_NZ   = 3'd4;
    localparam cond_t COND_OUT_BUSY = 3'd5;

    typedef struct packed {
        logic  load;
        logic  div_init;
        logic  div_step;
        logic  acc_sum;
        logic  emit;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic d_ge_n;
        logic cnt_nz;
        logic out_busy;
    } status_t;

    // The microprogram.
    function automatic ctrl_t ucode_rom(input upc_t upc);
        ctrl_t cw;
        cw = '0;
        unique case (upc)
            UPC_IDLE: begin
                cw.load   = 1'b1;
                cw.cond   = COND_NO_INPUT;
                cw.target = UPC_IDLE;
            end
            UPC_TEST: begin
                cw.div_init = 1'b1;
                cw.cond     = COND_D_GE_N;
                cw.target   = UPC_WAIT;
            end
            UPC_DIV: begin
                cw.div_step = 1'b1;
                cw.cond     = COND_CNT_NZ;
                cw.target   = UPC_DIV;
            end
            UPC_ACC: begin
                cw.acc_sum = 1'b1;
                cw.cond    = COND_ALWAYS;
                cw.target  = UPC_TEST;
            end
            UPC_WAIT: begin
                cw.cond   = COND_OUT_BUSY;
                cw.target = UPC_WAIT;
            end
            UPC_EMIT: begin
                cw.emit   = 1'b1;
                cw.cond   = COND_ALWAYS;
                cw.target = UPC_IDLE;
            end
            default: begin
                cw.cond   = COND_ALWAYS;
                cw.target = UPC_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/core/pnt_sequencer.sv
module pnt_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  pnt_pkg::status_t  status,
    output pnt_pkg::ctrl_t    ctrl
);
    import pnt_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic jump;

    assign ctrl = ucode_rom(upc_reg);

    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !status.in_valid;
            COND_D_GE_N:   jump = status.d_ge_n;
            COND_CNT_NZ:   jump = status.cnt_nz;
            COND_OUT_BUSY: jump = status.out_busy;
            default:       jump = 1'b1;
        endcase
        upc_next = jump ? ctrl.target : upc_t'(upc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> rtl/core/pnt_datapath.sv
module pnt_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pnt_pkg::ctrl_t                     ctrl,
    input  logic                               load_en,
    input  logic [pnt_pkg::CAND_WIDTH-1:0]     candidate,
    output logic                               d_ge_n,
    output logic                               cnt_nz,
    output logic                               perfect,
    output logic [pnt_pkg::SUM_OUT_WIDTH-1:0]  sum_sat
);
    import pnt_pkg::*;

    logic [USE_WIDTH-1:0] n_reg,     n_next;
    logic [USE_WIDTH-1:0] d_reg,     d_next;
    logic [USE_WIDTH-1:0] rem_reg,   rem_next;
    logic [USE_WIDTH-1:0] shift_reg, shift_next;
    logic [CNT_WIDTH-1:0] cnt_reg,   cnt_next;
    logic [SUM_WIDTH-1:0] sum_reg,   sum_next;

    logic [USE_WIDTH:0]   partial;
    logic [USE_WIDTH:0]   diff;
    logic [SAT_WIDTH-1:0] sum_wide;

    // One restoring remainder step: bring down the next bit of n, subtract d if it fits.
    assign partial = {rem_reg, shift_reg[USE_WIDTH-1]};
    assign diff    = partial - {1'b0, d_reg};

    assign d_ge_n = (d_reg >= n_reg);
    assign cnt_nz = (cnt_reg != '0);

    always_comb begin
        n_next     = n_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        if (load_en) begin
            n_next   = candidate[USE_WIDTH-1:0];
            d_next   = USE_WIDTH'(1);
            sum_next = '0;
        end
        if (ctrl.div_init) begin
            rem_next   = '0;
            shift_next = n_reg;
            cnt_next   = CNT_LAST;
        end
        if (ctrl.div_step) begin
            rem_next   = diff[USE_WIDTH] ? partial[USE_WIDTH-1:0] : diff[USE_WIDTH-1:0];
            shift_next = {shift_reg[USE_WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
        end
        if (ctrl.acc_sum) begin
            if (rem_reg == '0) begin
                sum_next = sum_reg + SUM_WIDTH'(d_reg);
            end
            d_next = d_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        sum_reg   <= sum_next;
    end

    assign perfect  = (n_reg != '0) && (sum_reg == SUM_WIDTH'(n_reg));
    assign sum_wide = SAT_WIDTH'(sum_reg);
    assign sum_sat  = (sum_wide > SAT_WIDTH'(SUM_OUT_MAX)) ? SUM_OUT_WIDTH'(SUM_OUT_MAX)
                                                          : sum_wide[SUM_OUT_WIDTH-1:0];

    // A remainder is only worked out for a trial divisor in the range 1 to n minus 1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_step |-> (d_reg < n_reg) && (d_reg != '0))
        else $error("remainder step with a trial divisor out of range");

endmodule

>>> rtl/core/perfect_number_test.sv
// Channel   Direction  Ports                                  Word
// s_        in         s_valid, s_ready, s_candidate[15:0]    one value to test
// m_        out        m_valid, m_ready, m_is_perfect,        proper divisor sum
//                      m_divisor_sum[17:0]                    and perfection flag
//
// For a candidate n the trial divisors run from 1 to n - 1, and each trial divisor
// costs one test step, one step of the bit-serial remainder unit per candidate bit
// and one accumulate step.
// Reset is synchronous and active low; it returns the sequencer to its idle step and
// empties the output register. Nothing else needs clearing.
// The block works on one word at a time. A finished result waits in the output
// register, and a new word is taken while it waits; a stalled result only holds the
// sequencer once the next result is ready to be written.
module perfect_number_test (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pnt_pkg::CAND_WIDTH-1:0]     s_candidate,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_is_perfect,
    output logic [pnt_pkg::SUM_OUT_WIDTH-1:0]  m_divisor_sum
);
    import pnt_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    logic                     d_ge_n;
    logic                     cnt_nz;
    logic                     perfect;
    logic [SUM_OUT_WIDTH-1:0] sum_sat;

    logic                     m_valid_reg,   m_valid_next;
    logic                     perfect_reg,   perfect_next;
    logic [SUM_OUT_WIDTH-1:0] sum_out_reg,   sum_out_next;

    // The sequencer takes a new word only in its idle step.
    assign s_ready = ctrl.load;

    assign status.in_valid = s_valid;
    assign status.d_ge_n   = d_ge_n;
    assign status.cnt_nz   = cnt_nz;
    assign status.out_busy = m_valid_reg && !m_ready;

    pnt_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    pnt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .load_en   (ctrl.load && s_valid),
        .candidate (s_candidate),
        .d_ge_n    (d_ge_n),
        .cnt_nz    (cnt_nz),
        .perfect   (perfect),
        .sum_sat   (sum_sat)
    );

    // Output register: the emit step is only reached once the register is free.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        perfect_next = perfect_reg;
        sum_out_next = sum_out_reg;
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
            perfect_next = perfect;
            sum_out_next = sum_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        perfect_reg <= perfect_next;
        sum_out_reg <= sum_out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_is_perfect  = perfect_reg;
    assign m_divisor_sum = sum_out_reg;

    // A new result is never written over one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> !m_valid_reg || m_ready)
        else $error("result written while the output register is still occupied");

    // Once a word is taken the sequencer leaves its idle step at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer stayed idle after taking a word");

    // A perfect value is never zero, so its divisor sum cannot be zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_perfect) |-> (m_divisor_sum != '0))
        else $error("perfect flag set with a zero divisor sum");

endmodule
